// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, muted while rst_n is low
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ihc_pkg.sv =====
// Types and constants of the incubator heater controller
`timescale 1ns / 1ps

package ihc_pkg;

  // Error above which the heater runs fully on (hundredths of a degree)
  localparam logic signed [16:0] FULL_ON_ERR = 17'sd150;
  // Phase length = error * PHASE_GAIN + PHASE_BASE milliseconds
  localparam logic [11:0] PHASE_GAIN = 12'd20;
  localparam logic [11:0] PHASE_BASE = 12'd1000;
  // Half width of the zone around the setpoint that rearms the beep
  localparam logic signed [16:0] ZONE_HALF = 17'sd10;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // Top overshoot margins
  localparam logic [8:0] MARGIN_AMT_IDLE   = 9'd500;
  localparam logic [8:0] MARGIN_AMT_FULL   = 9'd400;
  localparam logic [8:0] MARGIN_AMT_TOGGLE = 9'd130;

  // Register reset values
  localparam logic [12:0]        SETPOINT_RST   = 13'd3750;
  localparam logic signed [14:0] LIMIT_HIGH_RST = 15'sd3790;
  localparam logic signed [14:0] LIMIT_LOW_RST  = 15'sd3730;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SETPOINT   = 2'd0,
    CFG_LIMIT_HIGH = 2'd1,
    CFG_LIMIT_LOW  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    MARGIN_IDLE   = 2'd0,
    MARGIN_FULL   = 2'd1,
    MARGIN_TOGGLE = 2'd2
  } margin_sel_t;

  typedef struct packed {
    logic               toggle_phase;
    logic [15:0]        elapsed_ms;
    margin_sel_t        margin;
    logic               stable;
    logic               beep_block;
  } state_t;

  typedef struct packed {
    logic signed [14:0] temp_bottom;
    logic signed [14:0] temp_top;
    logic               ack;
  } item_t;

  typedef struct packed {
    logic heater_on;
    logic beep;
    logic warning;
    logic stable_flag;
  } result_t;

  localparam state_t STATE_RST = '{
    toggle_phase: 1'b1,
    elapsed_ms:   16'd0,
    margin:       MARGIN_IDLE,
    stable:       1'b0,
    beep_block:   1'b0
  };

  function automatic logic [8:0] margin_amount(input margin_sel_t sel);
    logic [8:0] amt;
    case (sel)
      MARGIN_FULL:   amt = MARGIN_AMT_FULL;
      MARGIN_TOGGLE: amt = MARGIN_AMT_TOGGLE;
      default:       amt = MARGIN_AMT_IDLE;
    endcase
    return amt;
  endfunction

endpackage

// ===== design/ihc_if.sv =====
// Valid/ready channel interfaces for the input and result beats
`timescale 1ns / 1ps

interface ihc_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temp_bottom;
  logic signed [14:0] temp_top;
  logic               ack;

  modport source (output valid, temp_bottom, temp_top, ack, input ready);
  modport sink (input valid, temp_bottom, temp_top, ack, output ready);
endinterface

interface ihc_out_if;
  logic valid;
  logic ready;
  logic heater_on;
  logic beep;
  logic warning;
  logic stable_flag;

  modport source (output valid, heater_on, beep, warning, stable_flag, input ready);
  modport sink (input valid, heater_on, beep, warning, stable_flag, output ready);
endinterface

// ===== design/ihc_step.sv =====
// Per-tick control decision: heater, beep, warning and next state
`timescale 1ns / 1ps

module ihc_step (
  input  ihc_pkg::state_t     st,
  input  ihc_pkg::item_t      item,
  input  logic [12:0]         setpoint,
  input  logic signed [14:0]  limit_high,
  input  logic signed [14:0]  limit_low,
  output ihc_pkg::state_t     st_nxt,
  output ihc_pkg::result_t    res
);

  logic signed [16:0] sp_x;
  logic signed [16:0] bot_x;
  logic signed [16:0] err;
  logic signed [17:0] top_x;
  logic signed [17:0] top_lim;
  logic signed [17:0] margin_x;
  logic               e_pos;
  logic               e_full;
  logic               e_zero;
  logic               outside;
  logic               in_zone;
  logic [11:0]        phase_len;
  logic [15:0]        elapsed_inc;
  ihc_pkg::margin_sel_t margin_new;
  logic               heater;
  logic               beep;
  logic               warn;

  assign sp_x   = {4'b0000, setpoint};
  assign bot_x  = {{2{item.temp_bottom[14]}}, item.temp_bottom};
  assign err    = sp_x - bot_x;
  assign e_zero = (err == 17'sd0);
  assign e_pos  = !err[16] && !e_zero;
  assign e_full = e_pos && (err > ihc_pkg::FULL_ON_ERR);

  assign outside = (item.temp_bottom >= limit_high) || (item.temp_bottom <= limit_low);
  assign in_zone = (bot_x >= sp_x - ihc_pkg::ZONE_HALF) && (bot_x <= sp_x + ihc_pkg::ZONE_HALF);

  // Only used for errors up to the full-on threshold, so 12 bits hold it
  assign phase_len = ({4'b0000, err[7:0]} * ihc_pkg::PHASE_GAIN) + ihc_pkg::PHASE_BASE;

  assign elapsed_inc = (st.elapsed_ms != ihc_pkg::ELAPSED_MAX) ? st.elapsed_ms + 16'd1
                                                                 : st.elapsed_ms;

  always_comb begin
    if (e_full) begin
      margin_new = ihc_pkg::MARGIN_FULL;
    end else if (e_pos) begin
      margin_new = ihc_pkg::MARGIN_TOGGLE;
    end else begin
      margin_new = st.margin;
    end
  end

  // Top limit = setpoint + error + margin
  assign margin_x = {9'd0, ihc_pkg::margin_amount(margin_new)};
  assign top_lim  = {sp_x[16], sp_x} + {err[16], err} + margin_x;
  assign top_x    = {{3{item.temp_top[14]}}, item.temp_top};

  always_comb begin
    st_nxt            = st;
    st_nxt.elapsed_ms = elapsed_inc;
    heater            = 1'b0;
    beep              = 1'b0;
    warn              = 1'b0;

    if (st.stable && outside) begin
      // Blocked in the warning: hold phase and margin
      warn = 1'b1;
      if (item.ack) begin
        st_nxt.stable = 1'b0;
      end
    end else begin
      st_nxt.margin = margin_new;
      if (e_full) begin
        heater = 1'b1;
      end else if (e_pos) begin
        if (elapsed_inc >= {4'b0000, phase_len}) begin
          st_nxt.elapsed_ms   = 16'd0;
          st_nxt.toggle_phase = ~st.toggle_phase;
        end
        heater = st_nxt.toggle_phase;
      end

      if (!e_pos || (top_x > top_lim)) begin
        heater = 1'b0;
      end

      if (e_zero && !st.stable && !st.beep_block) begin
        st_nxt.stable     = 1'b1;
        st_nxt.beep_block = 1'b1;
        beep              = 1'b1;
      end
      if (in_zone) begin
        st_nxt.beep_block = 1'b0;
      end

      if (st_nxt.stable && outside) begin
        warn   = 1'b1;
        heater = 1'b0;
        if (item.ack) begin
          st_nxt.stable = 1'b0;
        end
      end
    end

    res.heater_on   = heater;
    res.beep        = beep;
    res.warning     = warn;
    res.stable_flag = st_nxt.stable;
  end

endmodule

// ===== design/incubator_heater_controller_core.sv =====
// Top level of the incubator heater controller
//
// One input beat per millisecond tick on in_bus: bottom and top temperature
// in hundredths of a degree (signed) and an acknowledge bit. Every input beat
// yields exactly one result beat on out_bus: heater drive, one-tick beep,
// warning and the stable flag.
// The input beat lands in an input register; the control decision runs
// combinationally from that register into the result register, from which
// the result is presented on out_bus. One beat per cycle is sustained while
// out_bus takes every result beat.
// When out_bus stalls, the result register holds and the input register
// fills; in_bus.ready drops only when both are occupied.
// cfg_we with cfg_index writes setpoint (0), limit_high (1) or limit_low (2);
// other indexes are ignored. Write registers only while no beat is in flight.
// Synchronous reset (rst_n low) restores the register defaults, heater phase
// on, elapsed time zero, margin 5.00, not stable, and empties both stages.
`timescale 1ns / 1ps

module incubator_heater_controller_core (
  input  logic             clk,
  input  logic             rst_n,
  ihc_in_if.sink           in_bus,
  ihc_out_if.source        out_bus,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [14:0]      cfg_data
);

  logic [12:0]        setpoint_r;
  logic signed [14:0] limit_high_r;
  logic signed [14:0] limit_low_r;

  logic               in_valid_r;
  logic               in_valid_nxt;
  ihc_pkg::item_t     item_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  ihc_pkg::result_t   res_r;
  ihc_pkg::result_t   res_nxt;
  ihc_pkg::state_t    state_r;
  ihc_pkg::state_t    state_nxt;

  logic               advance;
  logic               fire;
  logic               in_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= ihc_pkg::SETPOINT_RST;
      limit_high_r <= ihc_pkg::LIMIT_HIGH_RST;
      limit_low_r  <= ihc_pkg::LIMIT_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ihc_pkg::CFG_SETPOINT:   setpoint_r   <= cfg_data[12:0];
        ihc_pkg::CFG_LIMIT_HIGH: limit_high_r <= cfg_data;
        ihc_pkg::CFG_LIMIT_LOW:  limit_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register frees up when empty or being taken
  assign advance       = !out_valid_r || out_bus.ready;
  assign fire          = in_valid_r && advance;
  assign in_bus.ready  = !in_valid_r || advance;
  assign in_take       = in_bus.valid && in_bus.ready;

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = fire || (out_valid_r && !out_bus.ready);

  ihc_step u_step (
    .st         (state_r),
    .item       (item_r),
    .setpoint   (setpoint_r),
    .limit_high (limit_high_r),
    .limit_low  (limit_low_r),
    .st_nxt     (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ihc_pkg::STATE_RST;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.temp_bottom <= in_bus.temp_bottom;
      item_r.temp_top    <= in_bus.temp_top;
      item_r.ack         <= in_bus.ack;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.heater_on   = res_r.heater_on;
  assign out_bus.beep        = res_r.beep;
  assign out_bus.warning     = res_r.warning;
  assign out_bus.stable_flag = res_r.stable_flag;

endmodule

// ===== design/ihc_checker.sv =====
// Port-level checks of the heater controller, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ihc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic heater_on,
  input logic beep,
  input logic warning,
  input logic stable_flag
);

  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid, "result beat right after reset")
  `ASSERT_RST(a_warn_cuts_heat, clk, rst_n, out_valid |-> !(heater_on && warning), "heater on during warning")
  `ASSERT_RST(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable({heater_on, beep, warning, stable_flag}), "stalled result beat changed")

endmodule

bind incubator_heater_controller_core ihc_checker u_ihc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .heater_on   (out_bus.heater_on),
  .beep        (out_bus.beep),
  .warning     (out_bus.warning),
  .stable_flag (out_bus.stable_flag)
);

// ===== dv/incubator_heater_controller_core_tb.sv =====
// Self-checking testbench for incubator_heater_controller_core with a per-tick predictor
`timescale 1ns / 1ps

module incubator_heater_controller_core_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int GAP_MAX = 17;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;

  ihc_in_if in_bus ();
  ihc_out_if out_bus ();

  incubator_heater_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor copy of the registers and the controller state
  logic [12:0] sp_reg = ihc_pkg::SETPOINT_RST;
  logic signed [14:0] hi_reg = ihc_pkg::LIMIT_HIGH_RST;
  logic signed [14:0] lo_reg = ihc_pkg::LIMIT_LOW_RST;
  logic phase_on = 1'b1;
  logic [15:0] ms_since_toggle = 16'd0;
  ihc_pkg::margin_sel_t margin_mode = ihc_pkg::MARGIN_IDLE;
  logic is_stable = 1'b0;
  logic beep_block = 1'b0;

  ihc_pkg::result_t due_outputs[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit send_gaps_on = 1'b1;
  bit recv_stalls_on = 1'b1;

  // One millisecond tick of the controller; updates the predictor state
  function automatic ihc_pkg::result_t control_tick(input ihc_pkg::item_t it);
    ihc_pkg::result_t r;
    int bot, top, sp, hi, lo, err, span, margin;
    bit outside;
    bot = int'(it.temp_bottom);
    top = int'(it.temp_top);
    sp = int'(sp_reg);
    hi = int'(hi_reg);
    lo = int'(lo_reg);
    err = sp - bot;
    outside = (bot >= hi) || (bot <= lo);
    r = '0;
    if (ms_since_toggle != ihc_pkg::ELAPSED_MAX) ms_since_toggle++;
    if (is_stable && outside) begin
      // blocked tick: only the warning runs
      r.warning = 1'b1;
      if (it.ack) is_stable = 1'b0;
    end else begin
      if (err > 0) begin
        if (err > int'(ihc_pkg::FULL_ON_ERR)) begin
          r.heater_on = 1'b1;
          margin_mode = ihc_pkg::MARGIN_FULL;
        end else begin
          span = err * int'(ihc_pkg::PHASE_GAIN) + int'(ihc_pkg::PHASE_BASE);
          margin_mode = ihc_pkg::MARGIN_TOGGLE;
          if (int'(ms_since_toggle) >= span) begin
            ms_since_toggle = 16'd0;
            phase_on = ~phase_on;
          end
          r.heater_on = phase_on;
        end
      end
      case (margin_mode)
        ihc_pkg::MARGIN_FULL:   margin = int'(ihc_pkg::MARGIN_AMT_FULL);
        ihc_pkg::MARGIN_TOGGLE: margin = int'(ihc_pkg::MARGIN_AMT_TOGGLE);
        default:                margin = int'(ihc_pkg::MARGIN_AMT_IDLE);
      endcase
      if (err <= 0 || top > sp + err + margin) r.heater_on = 1'b0;
      if (err == 0 && !is_stable && !beep_block) begin
        is_stable = 1'b1;
        beep_block = 1'b1;
        r.beep = 1'b1;
      end
      if (bot >= sp - int'(ihc_pkg::ZONE_HALF) && bot <= sp + int'(ihc_pkg::ZONE_HALF))
        beep_block = 1'b0;
      if (is_stable && outside) begin
        r.warning = 1'b1;
        r.heater_on = 1'b0;
        if (it.ack) is_stable = 1'b0;
      end
    end
    r.stable_flag = is_stable;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic want, input logic got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // Predict on each accepted input beat, check each accepted result beat
  always @(posedge clk) begin : check_results
    ihc_pkg::item_t beat;
    ihc_pkg::result_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        beat.temp_bottom = in_bus.temp_bottom;
        beat.temp_top = in_bus.temp_top;
        beat.ack = in_bus.ack;
        due_outputs.push_back(control_tick(beat));
      end
      if (out_bus.valid && out_bus.ready) begin
        if (due_outputs.size() == 0) begin
          report_mismatch("result beat with no tick pending", 1'b0, 1'b1);
        end else begin
          want = due_outputs.pop_front();
          if (out_bus.heater_on !== want.heater_on)
            report_mismatch("heater_on", want.heater_on, out_bus.heater_on);
          if (out_bus.beep !== want.beep)
            report_mismatch("beep", want.beep, out_bus.beep);
          if (out_bus.warning !== want.warning)
            report_mismatch("warning", want.warning, out_bus.warning);
          if (out_bus.stable_flag !== want.stable_flag)
            report_mismatch("stable_flag", want.stable_flag, out_bus.stable_flag);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("incubator_heater_controller_core regression: fail");
      $finish;
    end
  end

  // Result side: while stalls are on, drop ready for a random stall before each beat
  initial begin : result_sink
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = recv_stalls_on ? int'($urandom_range(0, GAP_MAX)) : 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
    end
  end

  function automatic ihc_pkg::item_t mk_tick(input int bot, input int top, input bit ack);
    ihc_pkg::item_t t;
    t.temp_bottom = bot[14:0];
    t.temp_top = top[14:0];
    t.ack = ack;
    return t;
  endfunction

  // Call right after a rising edge; returns at the edge that takes the beat
  task automatic send_tick(input ihc_pkg::item_t t);
    int gap;
    gap = send_gaps_on ? int'($urandom_range(0, GAP_MAX)) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.temp_bottom <= t.temp_bottom;
    in_bus.temp_top <= t.temp_top;
    in_bus.ack <= t.ack;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  // Hold off input until every pending result has come out
  task automatic drain_ticks();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (due_outputs.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [14:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ihc_pkg::CFG_SETPOINT:   sp_reg = data[12:0];
      ihc_pkg::CFG_LIMIT_HIGH: hi_reg = data;
      ihc_pkg::CFG_LIMIT_LOW:  lo_reg = data;
      default: ;
    endcase
  endtask

  task automatic configure(input int sp, input int hi, input int lo);
    drain_ticks();
    program_reg(ihc_pkg::CFG_SETPOINT, sp[14:0]);
    program_reg(ihc_pkg::CFG_LIMIT_HIGH, hi[14:0]);
    program_reg(ihc_pkg::CFG_LIMIT_LOW, lo[14:0]);
  endtask

  // Ticks around the setpoint with random content, or random noise
  function automatic ihc_pkg::item_t pick_tick(input bit noise);
    int bot, top, sp, margin;
    sp = int'(sp_reg);
    if (noise)
      return mk_tick(int'($urandom_range(0, 32767)), int'($urandom_range(0, 32767)),
                     $urandom_range(0, 1) != 0);
    case ($urandom_range(0, 5))
      0:       bot = sp;
      1:       bot = sp + int'($urandom_range(0, 20)) - 10;
      2:       bot = sp - int'($urandom_range(1, 150));
      3:       bot = sp - int'($urandom_range(140, 400));
      default: bot = sp + int'($urandom_range(0, 160)) - 80;
    endcase
    case ($urandom_range(0, 2))
      0:       margin = int'(ihc_pkg::MARGIN_AMT_IDLE);
      1:       margin = int'(ihc_pkg::MARGIN_AMT_FULL);
      default: margin = int'(ihc_pkg::MARGIN_AMT_TOGGLE);
    endcase
    // land near the overshoot threshold half of the time
    if ($urandom_range(0, 1))
      top = 2 * sp - bot + margin + int'($urandom_range(0, 4)) - 2;
    else
      top = bot + int'($urandom_range(0, 600)) - 300;
    return mk_tick(bot, top, $urandom_range(0, 7) == 0);
  endfunction

  task automatic test_directed_ticks();
    send_tick(mk_tick(-16384, 16383, 1'b1));
    send_tick(mk_tick(16383, -16384, 1'b0));
    send_tick(mk_tick(3000, -16384, 1'b0));
    send_tick(mk_tick(3000, 4900, 1'b0));
    send_tick(mk_tick(3000, 4901, 1'b0));
    send_tick(mk_tick(3600, 4030, 1'b0));
    send_tick(mk_tick(3600, 4031, 1'b0));
    send_tick(mk_tick(3599, 3000, 1'b0));
    send_tick(mk_tick(3750, 3750, 1'b0));
    send_tick(mk_tick(3750, 3750, 1'b0));
    send_tick(mk_tick(3790, 3750, 1'b0));
    send_tick(mk_tick(3730, 3750, 1'b0));
    send_tick(mk_tick(3730, 3750, 1'b1));
    send_tick(mk_tick(3730, 3750, 1'b1));
    send_tick(mk_tick(3750, 3750, 1'b0));
    send_tick(mk_tick(3760, 3750, 1'b1));
    send_tick(mk_tick(3741, 3750, 1'b0));
  endtask

  task automatic test_register_extremes();
    // upper data bits of the setpoint write are dropped
    drain_ticks();
    program_reg(ihc_pkg::CFG_SETPOINT, 15'h6000 | 15'd3750);
    program_reg(ihc_pkg::CFG_LIMIT_HIGH, 15'd3750);
    program_reg(ihc_pkg::CFG_LIMIT_LOW, 15'h4000);
    // warning raised by the control tick itself, then the blocked tick
    send_tick(mk_tick(3750, 0, 1'b1));
    send_tick(mk_tick(3750, 0, 1'b0));
    send_tick(mk_tick(3750, 0, 1'b0));
    send_tick(mk_tick(-16384, 0, 1'b0));
    send_tick(mk_tick(-16384, 0, 1'b1));
    send_tick(mk_tick(-16384, 16383, 1'b0));

    configure(0, 16383, -16384);
    drain_ticks();
    program_reg(CFG_UNUSED, 15'h7FFF);
    send_tick(mk_tick(-16384, 16383, 1'b0));
    send_tick(mk_tick(0, 0, 1'b0));
    send_tick(mk_tick(16383, -16384, 1'b1));
    send_tick(mk_tick(-16384, -16384, 1'b0));

    // limits crossed: every tick is outside
    configure(8191, -16384, 16383);
    send_tick(mk_tick(8191, 0, 1'b0));
    send_tick(mk_tick(-16384, 0, 1'b0));
    send_tick(mk_tick(8191, 16383, 1'b1));
    send_tick(mk_tick(8100, 0, 1'b0));

    configure(int'(ihc_pkg::SETPOINT_RST), int'(ihc_pkg::LIMIT_HIGH_RST),
              int'(ihc_pkg::LIMIT_LOW_RST));
  endtask

  task automatic test_phase_toggle();
    configure(2000, 16383, -16384);
    send_gaps_on = 1'b0;
    recv_stalls_on = 1'b0;
    repeat (1100) send_tick(mk_tick(1999, -16384, 1'b0));
    repeat (30) send_tick(mk_tick(1850, 2000, 1'b0));
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  task automatic test_random_settings();
    int sp;
    for (int p = 0; p < 6; p++) begin
      sp = int'($urandom_range(1225, 4825));
      case (p)
        0: configure(sp, sp + int'($urandom_range(0, 60)), sp - int'($urandom_range(0, 60)));
        1: configure(1225, 12500, -4000);
        2: configure(4825, 4825, 4825);
        3: configure(int'($urandom_range(0, 32767)), int'($urandom_range(0, 32767)),
                     int'($urandom_range(0, 32767)));
        4: configure(sp, sp + int'($urandom_range(5, 30)), sp - int'($urandom_range(5, 30)));
        default: configure(sp, -4000, 12500);
      endcase
      for (int n = 0; n < 65; n++) begin
        if (n % 40 == 0) begin
          send_gaps_on = $urandom_range(0, 3) != 0;
          recv_stalls_on = $urandom_range(0, 3) != 0;
        end
        if (n == 32) drain_ticks();
        send_tick(pick_tick($urandom_range(0, 4) == 0));
      end
    end
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= ihc_pkg::CFG_SETPOINT;
    cfg_data <= '0;
    in_bus.valid <= 1'b0;
    in_bus.temp_bottom <= '0;
    in_bus.temp_top <= '0;
    in_bus.ack <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_ticks();
    test_register_extremes();
    test_phase_toggle();
    test_random_settings();

    drain_ticks();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("incubator_heater_controller_core regression: pass");
    end else begin
      $display("incubator_heater_controller_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/ihc_pkg.sv
design/ihc_if.sv
design/ihc_step.sv
design/incubator_heater_controller_core.sv
design/ihc_checker.sv
dv/incubator_heater_controller_core_tb.sv
